>>> hdl/dpatm_pkg.sv
package dpatm_pkg;

  // Sizes of the fields and of the query store.
  localparam int NUM_BINS = 128;
  localparam int BIN_W    = 7;
  localparam int BIN_AW   = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
  localparam int DATA_W   = 16;
  localparam int TOKEN_W  = 16;
  localparam int SUM_W    = 32;
  localparam int PROD_W   = SUM_W + DATA_W;
  localparam int Q_SHIFT  = 15;

  localparam logic signed [DATA_W-1:0] TEMP_RESET  = 16'sd27852;
  localparam logic        [SUM_W-1:0]  SCORE_FLOOR = 32'h8000_0001;

  // Request kinds.
  typedef enum logic [1:0] {
    KIND_QUERY = 2'd0,
    KIND_COEF  = 2'd1,
    KIND_END   = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_ACC,
    ST_SCALE,
    ST_CMP
  } ctrl_state_e;

  typedef struct packed {
    logic [1:0]                kind;
    logic [BIN_W-1:0]          bin_index;
    logic signed [DATA_W-1:0]  sample_value;
    logic [TOKEN_W-1:0]        entry_token;
    logic                      entry_done;
  } in_req_t;

  typedef struct packed {
    logic [TOKEN_W-1:0] winning_token;
    logic               entry_seen;
  } out_req_t;

  // Strobes from the sequencer to the datapath.
  typedef struct packed {
    logic capture;
    logic mul_coef;
    logic mul_scale;
    logic accumulate;
    logic compare;
    logic clear;
  } ctrl_t;

  function automatic logic bin_in_range(input logic [BIN_W-1:0] bin);
    return (32'(bin) < 32'(NUM_BINS));
  endfunction

endpackage

>>> hdl/dpatm_ram.sv
module dpatm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 128,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hdl/dpatm_ctrl.sv
module dpatm_ctrl import dpatm_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic [1:0] kind_i,
  input  logic       entry_done_i,
  output logic       idle_o,
  output ctrl_t      ctrl_o
);

  ctrl_state_e state_q, state_d;
  logic        done_q, done_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_comb begin
    state_d = state_q;
    done_d  = done_q;
    ctrl_o  = '0;
    idle_o  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        idle_o = 1'b1;
        if (accept_i && (kind_i == KIND_COEF)) begin
          ctrl_o.capture = 1'b1;
          done_d         = entry_done_i;
          state_d        = ST_MUL;
        end
        if (accept_i && (kind_i == KIND_END)) begin
          ctrl_o.clear = 1'b1;
        end
      end
      ST_MUL: begin
        ctrl_o.mul_coef = 1'b1;
        state_d         = ST_ACC;
      end
      ST_ACC: begin
        ctrl_o.accumulate = 1'b1;
        state_d           = done_q ? ST_SCALE : ST_IDLE;
      end
      ST_SCALE: begin
        ctrl_o.mul_scale = 1'b1;
        state_d          = ST_CMP;
      end
      ST_CMP: begin
        ctrl_o.compare = 1'b1;
        state_d        = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

>>> hdl/dpatm_datapath.sv
module dpatm_datapath import dpatm_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  ctrl_t                     ctrl_i,
  input  logic [BIN_W-1:0]          bin_index_i,
  input  logic signed [DATA_W-1:0]  sample_value_i,
  input  logic [TOKEN_W-1:0]        entry_token_i,
  input  logic [DATA_W-1:0]         query_i,
  input  logic signed [DATA_W-1:0]  temperature_i,
  output logic [TOKEN_W-1:0]        best_token_o,
  output logic                      have_entry_o
);

  logic signed [DATA_W-1:0] sample_q;
  logic [TOKEN_W-1:0]       token_q;
  logic                     in_range_q;
  logic signed [PROD_W-1:0] prod_q;
  logic [SUM_W-1:0]         sum_q;
  logic [SUM_W-1:0]         best_q;
  logic [TOKEN_W-1:0]       best_tok_q;
  logic                     have_q;

  logic signed [SUM_W-1:0]  op_a;
  logic signed [DATA_W-1:0] op_b;
  logic signed [PROD_W-1:0] prod;
  logic [SUM_W-1:0]         shifted;

  // One shared multiplier: query times coefficient, or sum times temperature.
  always_comb begin
    if (ctrl_i.mul_scale) begin
      op_a = $signed(sum_q);
      op_b = temperature_i;
    end else begin
      op_a = in_range_q ? SUM_W'($signed(query_i)) : '0;
      op_b = sample_q;
    end
  end

  assign prod    = op_a * op_b;
  assign shifted = prod_q[Q_SHIFT+SUM_W-1:Q_SHIFT];

  always_ff @(posedge clk_i) begin
    if (ctrl_i.capture) begin
      sample_q   <= sample_value_i;
      token_q    <= entry_token_i;
      in_range_q <= bin_in_range(bin_index_i);
    end
    if (ctrl_i.mul_coef || ctrl_i.mul_scale) begin
      prod_q <= prod;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q      <= '0;
      best_q     <= SCORE_FLOOR;
      best_tok_q <= '0;
      have_q     <= 1'b0;
    end else if (ctrl_i.clear) begin
      sum_q      <= '0;
      best_q     <= SCORE_FLOOR;
      best_tok_q <= '0;
      have_q     <= 1'b0;
    end else if (ctrl_i.accumulate) begin
      sum_q <= sum_q + shifted;
    end else if (ctrl_i.compare) begin
      sum_q  <= '0;
      have_q <= 1'b1;
      if ($signed(shifted) > $signed(best_q)) begin
        best_q     <= shifted;
        best_tok_q <= token_q;
      end else if (!have_q) begin
        best_tok_q <= token_q;
      end
    end
  end

  assign best_token_o = best_tok_q;
  assign have_entry_o = have_q;

endmodule

>>> hdl/dot_product_argmax_template_match_unit.sv
// Dot-product template search with argmax. Query requests (kind 0) write a
// signed Q15 magnitude into a 128-entry query store; a bin must be written
// before a coefficient reads it. Coefficient requests (kind 1) read the
// stored magnitude, multiply it by the coefficient, shift the product right
// by 15 and add it into a wrapping 32-bit sum; the coefficient flagged
// entry_done closes the entry, whose sum is scaled by the signed Q15
// temperature register (reset 27852) and compared with the best score so far.
// An end request (kind 2) delivers the winning token (or 0 with entry_seen
// low if no entry was scored) and starts a fresh search while the query store
// keeps its contents. Kind 3 is accepted and ignored. A coefficient request
// runs the MUL and ACC states, the last of an entry also SCALE and CMP, as
// the single shared multiplier serves both the coefficient product and the
// temperature scaling, with a register after each multiply. The end request
// is taken as long as the output register is empty or being emptied in the
// same cycle, so a waiting result does not hold up other requests. The user
// must make temperature writes only while the block is idle (not enforced).
module dot_product_argmax_template_match_unit import dpatm_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  in_req_t                  in_req_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output out_req_t                 out_req_o,
  input  logic                     cfg_we_i,
  input  logic signed [DATA_W-1:0] cfg_wdata_i
);

  logic                     idle;
  logic                     in_accept;
  logic                     out_free;
  ctrl_t                    ctrl;
  logic [DATA_W-1:0]        query;
  logic [TOKEN_W-1:0]       best_token;
  logic                     have_entry;
  logic signed [DATA_W-1:0] temp_q;
  logic                     out_valid_q;
  out_req_t                 out_req_q;

  // The output register may be refilled in the cycle it is emptied.
  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = !idle || ((in_req_i.kind == KIND_END) && !out_free);
  assign in_accept  = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      temp_q <= TEMP_RESET;
    end else if (cfg_we_i) begin
      temp_q <= cfg_wdata_i;
    end
  end

  // Query store: written by query requests, read by coefficient requests.
  dpatm_ram #(
    .WIDTH (DATA_W),
    .DEPTH (NUM_BINS)
  ) u_query_store (
    .clk_i   (clk_i),
    .we_i    (in_accept && (in_req_i.kind == KIND_QUERY) &&
              bin_in_range(in_req_i.bin_index)),
    .waddr_i (BIN_AW'(in_req_i.bin_index)),
    .wdata_i (in_req_i.sample_value),
    .re_i    (ctrl.capture),
    .raddr_i (BIN_AW'(in_req_i.bin_index)),
    .rdata_o (query)
  );

  dpatm_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (in_accept),
    .kind_i       (in_req_i.kind),
    .entry_done_i (in_req_i.entry_done),
    .idle_o       (idle),
    .ctrl_o       (ctrl)
  );

  dpatm_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ctrl_i         (ctrl),
    .bin_index_i    (in_req_i.bin_index),
    .sample_value_i (in_req_i.sample_value),
    .entry_token_i  (in_req_i.entry_token),
    .query_i        (query),
    .temperature_i  (temp_q),
    .best_token_o   (best_token),
    .have_entry_o   (have_entry)
  );

  // Result register, loaded by an end request before the search is cleared.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl.clear) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.clear) begin
      out_req_q.winning_token <= have_entry ? best_token : '0;
      out_req_q.entry_seen    <= have_entry;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_req_q;

  // While the sequencer works through a coefficient, no request is taken.
  a_busy_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !idle |-> in_stall_o)
    else $error("request accepted while the sequencer was busy");

  // A coefficient request keeps the block busy in the following cycle.
  a_coef_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && (in_req_i.kind == KIND_COEF)) |=> !idle)
    else $error("coefficient request did not start the sequencer");

  // An end request always leaves a result waiting in the next cycle.
  a_end_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && (in_req_i.kind == KIND_END)) |=> (out_valid_o && !have_entry))
    else $error("end request did not deliver a result and clear the search");

  // An empty vocabulary reports token zero.
  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_req_o.entry_seen) |-> (out_req_o.winning_token == '0))
    else $error("non-zero token reported without a scored entry");

endmodule
